>>> rtl/tensor_pad_address_map_macros.svh
// assertion macros for the tensor pad address map
`ifndef TENSOR_PAD_ADDRESS_MAP_MACROS_SVH
`define TENSOR_PAD_ADDRESS_MAP_MACROS_SVH

// same-cycle implication, checked while out of reset
`define TPAM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpam check failed");

// next-cycle implication, checked while out of reset
`define TPAM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpam check failed");

`endif

>>> rtl/tpam_pkg.sv
// shared types and constants for the tensor pad address map
`default_nettype none

package tpam_pkg;

  localparam int unsigned MaxDims    = 4;
  localparam int unsigned DimFieldW  = 16;
  localparam int unsigned CoordW     = 32;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned RankW      = 3;
  localparam int unsigned ExtentW    = 32;
  localparam int unsigned IndexW     = 64;

  localparam logic [CfgIndexW-1:0] RegTensorRank = 3'd0;
  localparam logic [CfgIndexW-1:0] RegInputDims  = 3'd1;
  localparam logic [CfgIndexW-1:0] RegEdgeLow    = 3'd2;
  localparam logic [CfgIndexW-1:0] RegEdgeHigh   = 3'd3;
  localparam logic [CfgIndexW-1:0] RegInterior   = 3'd4;

  typedef enum logic [1:0] {
    StatusSource  = 2'd0,
    StatusPad     = 2'd1,
    StatusOutside = 2'd2
  } map_status_e;

  typedef struct packed {
    logic [CoordW-1:0] coord_dim0;
    logic [CoordW-1:0] coord_dim1;
    logic [CoordW-1:0] coord_dim2;
    logic [CoordW-1:0] coord_dim3;
  } in_t;

  typedef struct packed {
    logic [1:0]         map_status;
    logic [IndexW-1:0]  source_index;
    logic [ExtentW-1:0] out_extent_dim;
  } out_t;

  typedef struct packed {
    logic                 valid;
    logic                 outside;
    logic                 pad;
    logic                 osz_pos;
    logic [ExtentW-1:0]   extent;
    logic [DimFieldW-1:0] src;
  } lane_res_t;

  typedef struct packed {
    map_status_e        status;
    logic [ExtentW-1:0] extent;
  } merge_meta_t;

endpackage

`default_nettype wire

>>> rtl/tensor_pad_address_map.sv
// top level of the tensor pad address map
// throughput: one coordinate transfer per cycle while the skid stage is empty, set by
// fully pipelined lanes; each lane divides by interior+1 one quotient bit per stage,
// the merge runs one multiply per dimension after the first; reset empties the
// pipeline and loads rank 1, dim 0 size 1, pads 0
`default_nettype none

module tensor_pad_address_map #(
  parameter int unsigned MAX_DIMS        = tpam_pkg::MaxDims,
  parameter int unsigned DIM_FIELD_WIDTH = tpam_pkg::DimFieldW
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  tpam_pkg::in_t                        in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output tpam_pkg::out_t                       out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [tpam_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  wire logic [tpam_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  localparam int unsigned W = DIM_FIELD_WIDTH;

  logic [tpam_pkg::RankW-1:0]    rank_q;
  logic [tpam_pkg::CfgDataW-1:0] dims_q;
  logic [tpam_pkg::CfgDataW-1:0] low_q;
  logic [tpam_pkg::CfgDataW-1:0] high_q;
  logic [tpam_pkg::CfgDataW-1:0] interior_q;

  logic [tpam_pkg::RankW-1:0]    rank_sat;
  logic [tpam_pkg::CoordW-1:0]   coord [tpam_pkg::MaxDims];
  logic [W-1:0]                  dim_f [MAX_DIMS];
  tpam_pkg::lane_res_t           lane_res [MAX_DIMS];

  logic                          en;
  logic                          pipe_valid;
  tpam_pkg::out_t                pipe_data;
  logic                          take_out;

  logic                          out_valid_q;
  logic                          skid_valid_q;
  tpam_pkg::out_t                out_q;
  tpam_pkg::out_t                skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q     <= tpam_pkg::RankW'(1);
      dims_q     <= tpam_pkg::CfgDataW'(1);
      low_q      <= '0;
      high_q     <= '0;
      interior_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tpam_pkg::RegTensorRank: rank_q     <= cfg_wdata_i[tpam_pkg::RankW-1:0];
        tpam_pkg::RegInputDims:  dims_q     <= cfg_wdata_i;
        tpam_pkg::RegEdgeLow:    low_q      <= cfg_wdata_i;
        tpam_pkg::RegEdgeHigh:   high_q     <= cfg_wdata_i;
        tpam_pkg::RegInterior:   interior_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign rank_sat = (rank_q > tpam_pkg::RankW'(MAX_DIMS)) ? tpam_pkg::RankW'(MAX_DIMS)
                                                           : rank_q;

  assign coord[0] = in_data_i.coord_dim0;
  assign coord[1] = in_data_i.coord_dim1;
  assign coord[2] = in_data_i.coord_dim2;
  assign coord[3] = in_data_i.coord_dim3;

  assign en = !skid_valid_q;

  for (genvar i = 0; i < MAX_DIMS; i++) begin : g_lane
    assign dim_f[i] = dims_q[i*W +: W];

    tpam_lane #(
      .DIM_FIELD_WIDTH(W)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .valid_i    (in_valid_i),
      .coord_i    (coord[i]),
      .dim_i      (dims_q[i*W +: W]),
      .low_i      (low_q[i*W +: W]),
      .high_i     (high_q[i*W +: W]),
      .interior_i (interior_q[i*W +: W]),
      .res_o      (lane_res[i])
    );
  end

  tpam_merge #(
    .MAX_DIMS       (MAX_DIMS),
    .DIM_FIELD_WIDTH(W)
  ) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .rank_i (rank_sat),
    .dims_i (dim_f),
    .lanes_i(lane_res),
    .valid_o(pipe_valid),
    .data_o (pipe_data)
  );

  // output register with skid stage
  assign take_out = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (!out_stall_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (take_out) begin
      out_valid_q <= pipe_valid;
    end else if (pipe_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (!out_stall_i) begin
        out_q <= skid_q;
      end
    end else if (take_out) begin
      out_q <= pipe_data;
    end else begin
      skid_q <= pipe_data;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/tpam_lane.sv
// one dimension lane: output size, range check and pipelined position divide
`default_nettype none

module tpam_lane #(
  parameter int unsigned DIM_FIELD_WIDTH = tpam_pkg::DimFieldW
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire logic [tpam_pkg::CoordW-1:0] coord_i,
  input  wire logic [DIM_FIELD_WIDTH-1:0] dim_i,
  input  wire logic [DIM_FIELD_WIDTH-1:0] low_i,
  input  wire logic [DIM_FIELD_WIDTH-1:0] high_i,
  input  wire logic [DIM_FIELD_WIDTH-1:0] interior_i,
  output tpam_pkg::lane_res_t             res_o
);

  localparam int unsigned W     = DIM_FIELD_WIDTH;
  localparam int unsigned SW    = W + 1;
  localparam int unsigned RW    = W + 1;
  localparam int unsigned OSZ_W = 2 * W + 3;
  localparam int unsigned CMP_W = (OSZ_W > tpam_pkg::CoordW + 2) ? OSZ_W
                                                                 : tpam_pkg::CoordW + 2;
  localparam int unsigned N     = CMP_W - 1;
  localparam logic signed [CMP_W-1:0] One = 1;

  logic [SW-1:0]            step;
  logic signed [W:0]        dim_m1;
  logic signed [OSZ_W-1:0]  prod;
  logic signed [CMP_W-1:0]  osz_d;
  logic signed [CMP_W-1:0]  coord_ext;
  logic signed [CMP_W-1:0]  pos_d;

  logic                     v0_q;
  logic signed [CMP_W-1:0]  osz_q;
  logic signed [CMP_W-1:0]  coord_q;
  logic signed [CMP_W-1:0]  pos_q;

  logic                     vld_q  [1:N];
  logic [RW-1:0]            rem_q  [1:N];
  logic [N-1:0]             dvd_q  [1:N];
  logic [N-1:0]             quo_q  [1:N];
  logic                     out_q  [1:N];
  logic                     neg_q  [1:N];
  logic                     opos_q [1:N];
  logic [tpam_pkg::ExtentW-1:0] ext_q [1:N];

  assign step      = SW'(interior_i) + SW'(1);
  assign dim_m1    = $signed({1'b0, dim_i}) - $signed((W + 1)'(1));
  assign prod      = dim_m1 * $signed({1'b0, step});
  assign osz_d     = prod + One + $signed(low_i) + $signed(high_i);
  assign coord_ext = $signed({{(CMP_W - tpam_pkg::CoordW){1'b0}}, coord_i});
  assign pos_d     = coord_ext - $signed(low_i);

  // output size and offset from the low edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      osz_q   <= osz_d;
      coord_q <= coord_ext;
      pos_q   <= pos_d;
    end
  end

  // restoring divide by interior+1, one quotient bit per stage
  for (genvar k = 1; k <= N; k++) begin : g_div
    logic [RW-1:0] rem_in;
    logic [N-1:0]  dvd_in;
    logic [N-1:0]  quo_in;
    logic          v_in;
    logic          o_in;
    logic          n_in;
    logic          p_in;
    logic [tpam_pkg::ExtentW-1:0] e_in;
    logic [RW:0]   trial;
    logic [RW:0]   diff;
    logic          ge;

    if (k == 1) begin : g_first
      assign rem_in = '0;
      assign dvd_in = pos_q[N-1:0];
      assign quo_in = '0;
      assign v_in   = v0_q;
      assign o_in   = (coord_q >= osz_q);
      assign n_in   = pos_q[CMP_W-1];
      assign p_in   = !osz_q[CMP_W-1] && (|osz_q);
      assign e_in   = osz_q[tpam_pkg::ExtentW-1:0];
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign dvd_in = dvd_q[k-1];
      assign quo_in = quo_q[k-1];
      assign v_in   = vld_q[k-1];
      assign o_in   = out_q[k-1];
      assign n_in   = neg_q[k-1];
      assign p_in   = opos_q[k-1];
      assign e_in   = ext_q[k-1];
    end

    assign trial = {rem_in, dvd_in[N-k]};
    assign diff  = trial - {1'b0, step};
    assign ge    = (trial >= {1'b0, step});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[RW-1:0] : trial[RW-1:0];
        dvd_q[k]  <= dvd_in;
        quo_q[k]  <= {quo_in[N-2:0], ge};
        out_q[k]  <= o_in;
        neg_q[k]  <= n_in;
        opos_q[k] <= p_in;
        ext_q[k]  <= e_in;
      end
    end
  end

  always_comb begin
    res_o.valid   = vld_q[N];
    res_o.outside = out_q[N];
    res_o.pad     = neg_q[N] || (rem_q[N] != '0) || (quo_q[N] >= N'(dim_i));
    res_o.osz_pos = opos_q[N];
    res_o.extent  = ext_q[N];
    res_o.src     = tpam_pkg::DimFieldW'(quo_q[N][W-1:0]);
  end

endmodule

`default_nettype wire

>>> rtl/tpam_merge.sv
// merges lane results into status, row-major index and extent
`default_nettype none

module tpam_merge #(
  parameter int unsigned MAX_DIMS        = tpam_pkg::MaxDims,
  parameter int unsigned DIM_FIELD_WIDTH = tpam_pkg::DimFieldW
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic [tpam_pkg::RankW-1:0]   rank_i,
  input  wire logic [DIM_FIELD_WIDTH-1:0]   dims_i  [MAX_DIMS],
  input  tpam_pkg::lane_res_t               lanes_i [MAX_DIMS],
  output logic                              valid_o,
  output tpam_pkg::out_t                    data_o
);

  localparam int unsigned W = DIM_FIELD_WIDTH;

  logic                  active  [MAX_DIMS];
  logic [W-1:0]          src_d   [MAX_DIMS];
  logic [W-1:0]          dmul    [MAX_DIMS];
  logic                  empty;
  logic                  outside;
  logic                  pad;
  logic [tpam_pkg::ExtentW-1:0] extent;
  logic                  valid_d;
  tpam_pkg::merge_meta_t meta_d;

  logic                          vld_q  [MAX_DIMS];
  tpam_pkg::merge_meta_t         meta_q [MAX_DIMS];
  logic [tpam_pkg::IndexW-1:0]   acc_q  [MAX_DIMS];
  logic [W-1:0]                  src_q  [MAX_DIMS][MAX_DIMS];

  always_comb begin
    empty   = 1'b0;
    outside = 1'b0;
    pad     = 1'b0;
    extent  = '0;
    for (int i = 0; i < int'(MAX_DIMS); i++) begin
      active[i] = (i < int'(rank_i));
      src_d[i]  = active[i] ? lanes_i[i].src[W-1:0] : '0;
      dmul[i]   = active[i] ? dims_i[i] : W'(1);
      empty     = empty   || (active[i] && !lanes_i[i].osz_pos);
      outside   = outside || (active[i] && lanes_i[i].outside);
      pad       = pad     || (active[i] && lanes_i[i].pad);
      if (i + 1 == int'(rank_i)) begin
        extent = lanes_i[i].extent;
      end
    end
    valid_d = lanes_i[0].valid;
    priority if (rank_i == '0) begin
      meta_d.status = tpam_pkg::StatusSource;
      meta_d.extent = tpam_pkg::ExtentW'(1);
    end else if (empty) begin
      meta_d.status = tpam_pkg::StatusOutside;
      meta_d.extent = '0;
    end else if (outside) begin
      meta_d.status = tpam_pkg::StatusOutside;
      meta_d.extent = extent;
    end else if (pad) begin
      meta_d.status = tpam_pkg::StatusPad;
      meta_d.extent = extent;
    end else begin
      meta_d.status = tpam_pkg::StatusSource;
      meta_d.extent = extent;
    end
  end

  // horner chain, one multiply per stage after the head stage
  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_stage
    if (k == 0) begin : g_head
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[0] <= 1'b0;
        end else if (en_i) begin
          vld_q[0] <= valid_d;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          meta_q[0] <= meta_d;
          acc_q[0]  <= tpam_pkg::IndexW'(src_d[0]);
          src_q[0]  <= src_d;
        end
      end
    end else begin : g_mul
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else if (en_i) begin
          vld_q[k] <= vld_q[k-1];
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          meta_q[k] <= meta_q[k-1];
          acc_q[k]  <= acc_q[k-1] * tpam_pkg::IndexW'(dmul[k])
                       + tpam_pkg::IndexW'(src_q[k-1][k]);
          src_q[k]  <= src_q[k-1];
        end
      end
    end
  end

  always_comb begin
    valid_o                = vld_q[MAX_DIMS-1];
    data_o.map_status      = meta_q[MAX_DIMS-1].status;
    data_o.source_index    = (meta_q[MAX_DIMS-1].status == tpam_pkg::StatusSource)
                             ? acc_q[MAX_DIMS-1] : '0;
    data_o.out_extent_dim  = meta_q[MAX_DIMS-1].extent;
  end

endmodule

`default_nettype wire

>>> rtl/tpam_checker.sv
// port-level checks for the tensor pad address map, bound to the top level
`default_nettype none

`include "tensor_pad_address_map_macros.svh"

module tpam_checker (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_stall_o,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input tpam_pkg::out_t out_data_o
);

  `TPAM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  `TPAM_ASSERT_IMPL(a_status_code, clk_i, rst_ni, out_valid_o, out_data_o.map_status != 2'd3)
  `TPAM_ASSERT_IMPL(a_index_zero, clk_i, rst_ni, out_valid_o && (out_data_o.map_status != tpam_pkg::StatusSource), out_data_o.source_index == '0)
  `TPAM_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, $rose(in_stall_o), $past(out_valid_o && out_stall_i))

endmodule

bind tensor_pad_address_map tpam_checker u_checker (.*);

`default_nettype wire
